>>> sv/osbq_pkg.sv
// Shared types and constants for the ordered-set bound query block.
`default_nettype none
package osbq_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [CNT_W-1:0]        t_count;

    typedef enum logic [2:0] {
        MODE_INSERT = 3'd0,
        MODE_ERASE  = 3'd1,
        MODE_MIN    = 3'd2,
        MODE_MAX    = 3'd3,
        MODE_SUCC   = 3'd4,
        MODE_CEIL   = 3'd5,
        MODE_PRED   = 3'd6,
        MODE_FLOOR  = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_NONE  = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } t_state;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic  cmp;
        logic  ins;
        logic  ers;
        t_mode mode;
    } t_cell_ctl;

    // what a cell shows its neighbors
    typedef struct packed {
        t_key key;
        logic lt;
        logic le;
        logic occ;
    } t_nbr;

endpackage
`default_nettype wire

>>> sv/osbq_in_if.sv
// Input item channel: mode and key with valid/ready.
`default_nettype none
interface osbq_in_if
    import osbq_pkg::*;
;
    logic  valid;
    logic  ready;
    t_mode mode;
    t_key  key;

    modport source (output valid, output mode, output key, input ready);
    modport sink   (input valid, input mode, input key, output ready);
endinterface
`default_nettype wire

>>> sv/osbq_out_if.sv
// Result item channel: status and value with valid/ready.
`default_nettype none
interface osbq_out_if
    import osbq_pkg::*;
;
    logic    valid;
    logic    ready;
    t_status status;
    t_key    value;

    modport source (output valid, output status, output value, input ready);
    modport sink   (input valid, input status, input value, output ready);
endinterface
`default_nettype wire

>>> sv/osbq_cell.sv
// One cell of the sorted key list: holds a key, compares, shifts and selects.
`default_nettype none
module osbq_cell
    import osbq_pkg::*;
(
    input  wire        i_clk,
    input  t_cell_ctl  i_ctl,
    input  t_key       i_key,
    input  wire        i_occ,
    input  t_nbr       i_left,
    input  t_nbr       i_right,
    output t_nbr       o_nbr,
    output logic       o_sel,
    output t_key       o_val
);

    t_key r_key;
    logic r_lt;
    logic r_le;

    // compare against the argument, then shift on insert or erase
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_lt <= i_occ && (r_key < i_key);
            r_le <= i_occ && (r_key <= i_key);
        end
        if (i_ctl.ins && !r_lt) begin
            r_key <= i_left.lt ? i_key : i_left.key;
        end else if (i_ctl.ers && !r_lt) begin
            r_key <= i_right.key;
        end
    end

    // flag this cell when it holds the answer of the current query
    always_comb begin
        case (i_ctl.mode)
            MODE_MIN:   o_sel = i_occ && !i_left.occ;
            MODE_MAX:   o_sel = i_occ && !i_right.occ;
            MODE_SUCC:  o_sel = i_occ && !r_le && i_left.le;
            MODE_CEIL:  o_sel = i_occ && !r_lt && i_left.lt;
            MODE_PRED:  o_sel = r_lt && !i_right.lt;
            MODE_FLOOR: o_sel = r_le && !i_right.le;
            default:    o_sel = 1'b0;
        endcase
    end

    assign o_val     = o_sel ? r_key : '0;
    assign o_nbr.key = r_key;
    assign o_nbr.lt  = r_lt;
    assign o_nbr.le  = r_le;
    assign o_nbr.occ = i_occ;

endmodule
`default_nettype wire

>>> sv/ordered_set_bound_queries_core.sv
// Top level: sequencer, key count, result register and the row of key cells.
//
//  channel  dir  handshake      payload
//  i_in     in   valid/ready    mode[2:0], key[31:0] signed
//  o_out    out  valid/ready    status[1:0], value[31:0] signed
//
// Each item goes through capture, a parallel compare in all cells,
// then a shift or select over the cell row.
// Reset (synchronous, active low) empties the set; no clearing pass is needed.
// A finished result waits in the output register while the next item is taken;
// an item that yields a result holds in its last step until that register is free.
`default_nettype none
module ordered_set_bound_queries_core
    import osbq_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    osbq_in_if.sink     i_in,
    osbq_out_if.source  o_out
);

    t_state    r_state;
    t_state    n_state;
    t_mode     r_mode;
    t_key      r_key;
    t_count    r_count;
    t_count    n_count;
    logic      r_out_vld;
    t_status   r_status;
    t_key      r_value;

    t_nbr      nbr   [CAPACITY];
    t_nbr      left  [CAPACITY];
    t_nbr      right [CAPACITY];
    t_key      val   [CAPACITY];
    logic [CAPACITY-1:0] sel_vec;
    logic [CAPACITY-1:0] occ_vec;
    logic [CAPACITY-1:0] hit_vec;

    t_cell_ctl ctl;
    logic      present;
    logic      full;
    logic      ins_go;
    logic      ers_go;
    logic      has_res;
    logic      exec_fire;
    logic      found;
    t_key      found_val;
    t_status   res_status;

    // row of cells, each seeing its neighbors; the ends see fixed boundaries
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign occ_vec[g] = CNT_W'(g) < r_count;
        assign hit_vec[g] = nbr[g].le && !nbr[g].lt;

        if (g == 0) begin : g_head
            assign left[g] = '{key: '0, lt: 1'b1, le: 1'b1, occ: 1'b0};
        end else begin : g_mid_l
            assign left[g] = nbr[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign right[g] = '{key: '0, lt: 1'b0, le: 1'b0, occ: 1'b0};
        end else begin : g_mid_r
            assign right[g] = nbr[g+1];
        end

        osbq_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_key   (r_key),
            .i_occ   (occ_vec[g]),
            .i_left  (left[g]),
            .i_right (right[g]),
            .o_nbr   (nbr[g]),
            .o_sel   (sel_vec[g]),
            .o_val   (val[g])
        );
    end

    // gather the selected key
    always_comb begin
        found_val = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            found_val = found_val | val[i];
        end
    end

    assign found   = |sel_vec;
    assign present = |hit_vec;
    assign full    = (r_count == CNT_W'(CAPACITY));

    // decide the operation in the final step
    always_comb begin
        ins_go     = 1'b0;
        ers_go     = 1'b0;
        has_res    = 1'b0;
        res_status = ST_OK;
        unique case (r_mode)
            MODE_INSERT: begin
                ins_go     = !present && !full;
                has_res    = !present && full;
                res_status = ST_FULL;
            end
            MODE_ERASE: begin
                ers_go = present;
            end
            default: begin
                has_res = 1'b1;
                if (r_count == '0) begin
                    res_status = ST_EMPTY;
                end else if (found) begin
                    res_status = ST_OK;
                end else begin
                    res_status = ST_NONE;
                end
            end
        endcase
    end

    assign exec_fire = (r_state == S_EXEC) && (!has_res || !r_out_vld || o_out.ready);

    assign ctl.cmp  = (r_state == S_CMP);
    assign ctl.ins  = exec_fire && ins_go;
    assign ctl.ers  = exec_fire && ers_go;
    assign ctl.mode = r_mode;

    // sequencer next state
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) n_state = S_CMP;
            end
            S_CMP: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (exec_fire) begin
                    n_state = S_IDLE;
                    if (ins_go) n_count = r_count + 1'b1;
                    if (ers_go) n_count = r_count - 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign i_in.ready = (r_state == S_IDLE);

    // hold state, count and the result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (exec_fire && has_res) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // capture the item and the result payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_mode <= i_in.mode;
            r_key  <= i_in.key;
        end
        if (exec_fire && has_res) begin
            r_status <= res_status;
            r_value  <= (res_status == ST_OK) ? found_val : '0;
        end
    end

    assign o_out.valid  = r_out_vld;
    assign o_out.status = r_status;
    assign o_out.value  = r_value;

    // the key count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("key count above capacity");

    // a stored insert grows the set by exactly one
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.ins |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not grow the count");

    // at most one cell answers a query
    a_one_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXEC |-> $onehot0(sel_vec))
        else $error("several cells selected");

    // an accepted item is compared in the next cycle
    a_accept_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_state == S_CMP)
        else $error("accepted item not compared");

endmodule
`default_nettype wire

>>> tb/osbq_set_checker.sv
// Watches both item channels, keeps its own copy of the ordered set and checks every result.
module osbq_set_checker
    import osbq_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    osbq_in_if   i_in,
    osbq_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        t_status status;
        t_key    value;
    } t_answer;

    // ascending copy of the keys the block should hold
    t_key    held_keys[$];
    // answers still owed by the block, oldest first
    t_answer expected_answers[$];

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        o_fail_count++;
    endtask

    // count held keys below k, or not above k when or_equal is set
    function automatic int count_below(input t_key k, input bit or_equal);
        int n;
        n = 0;
        while (n < held_keys.size() &&
               (held_keys[n] < k || (or_equal && held_keys[n] == k)))
            n++;
        return n;
    endfunction

    // apply one accepted item to the set and queue the answer it owes
    task automatic predict_item(input t_mode op, input t_key arg);
        int      lo;
        int      hi;
        int      n;
        t_status st;
        t_key    v;
        bit      gives;
        lo    = count_below(arg, 1'b0);
        hi    = count_below(arg, 1'b1);
        n     = held_keys.size();
        st    = ST_OK;
        v     = '0;
        gives = 1'b1;
        case (op)
            MODE_INSERT: begin
                gives = 1'b0;
                // duplicates change nothing, even when full
                if (hi == lo) begin
                    if (n >= CAPACITY) begin
                        gives = 1'b1;
                        st    = ST_FULL;
                    end else begin
                        held_keys.insert(lo, arg);
                    end
                end
            end
            MODE_ERASE: begin
                gives = 1'b0;
                if (hi > lo) held_keys.delete(lo);
            end
            default: begin
                if (n == 0) begin
                    st = ST_EMPTY;
                end else begin
                    case (op)
                        MODE_MIN:  v = held_keys[0];
                        MODE_MAX:  v = held_keys[n-1];
                        MODE_SUCC: if (hi < n) v = held_keys[hi];   else st = ST_NONE;
                        MODE_CEIL: if (lo < n) v = held_keys[lo];   else st = ST_NONE;
                        MODE_PRED: if (lo > 0) v = held_keys[lo-1]; else st = ST_NONE;
                        default:   if (hi > 0) v = held_keys[hi-1]; else st = ST_NONE;
                    endcase
                end
            end
        endcase
        if (gives) expected_answers.push_back('{st, v});
    endtask

    // check results first, then predict the item taken on the same edge
    always @(posedge i_clk) begin : watch
        t_answer want;
        if (!i_rst_n) begin
            held_keys.delete();
            expected_answers.delete();
            o_pending <= 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (expected_answers.size() == 0) begin
                    report_mismatch($sformatf("result with none expected: status %0d value %0d",
                                              i_out.status, i_out.value));
                end else begin
                    want = expected_answers.pop_front();
                    if (i_out.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_out.status, want.status));
                    if (i_out.value !== want.value)
                        report_mismatch($sformatf("value %0d, expected %0d",
                                                  i_out.value, want.value));
                end
            end
            if (i_in.valid && i_in.ready) predict_item(i_in.mode, i_in.key);
            o_pending <= expected_answers.size();
        end
    end

endmodule

>>> tb/testbench.sv
// Top of the ordered-set testbench: clock, reset, item stimulus, idling and the verdict.
module testbench;
    import osbq_pkg::*;

    localparam t_key KEY_LOWEST   = 32'sh8000_0000;
    localparam t_key KEY_HIGHEST  = 32'sh7fff_ffff;
    localparam int   FILL_COUNT   = CAPACITY + 6;
    localparam int   DRAIN_CYCLES = 12;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending_count;
    int   send_idle_pct;
    int   recv_stall_pct;

    osbq_in_if  in_ch ();
    osbq_out_if out_ch ();

    ordered_set_bound_queries_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    osbq_set_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // free-running clock, period 2
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // stall the result channel at random
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // present one item after a random gap and hold it until accepted
    task automatic send_item(input t_mode op, input t_key arg);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode  <= op;
        in_ch.key   <= arg;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // hold off the sender until every owed result has come back
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending_count != 0);
    endtask

    function automatic t_mode any_query();
        return t_mode'($urandom_range(MODE_FLOOR, MODE_MIN));
    endfunction

    // mostly keys from a narrow pool so that inserts, erases and queries collide
    function automatic t_key pick_key();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70) return t_key'((int'($urandom_range(23)) - 12) * 7);
        if (sel < 85) begin
            case ($urandom_range(5))
                0:       return KEY_LOWEST;
                1:       return KEY_LOWEST + 1;
                2:       return KEY_HIGHEST;
                3:       return KEY_HIGHEST - 1;
                4:       return -1;
                default: return '0;
            endcase
        end
        return t_key'($urandom);
    endfunction

    // random mix of inserts, erases and queries
    task automatic run_churn(input int count);
        int sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < 35)      send_item(MODE_INSERT, pick_key());
            else if (sel < 55) send_item(MODE_ERASE, pick_key());
            else               send_item(any_query(), pick_key());
        end
    endtask

    // fill the set past capacity, probe it while full, then drain it again
    task automatic run_fill_drain();
        t_key base;
        t_key stride;
        t_key fill_keys[$];
        int   idx;
        base   = t_key'($urandom);
        stride = t_key'($urandom | 1);
        for (int n = 0; n < FILL_COUNT; n++) begin
            fill_keys.push_back(base + stride * n);
            send_item(MODE_INSERT, fill_keys[n]);
        end
        // repeat stored keys while full
        for (int n = 0; n < 4; n++)
            send_item(MODE_INSERT, fill_keys[$urandom_range(CAPACITY - 1)]);
        for (int n = 0; n < 12; n++) begin
            idx = $urandom_range(FILL_COUNT - 1);
            if (n % 2 == 0) send_item(any_query(), pick_key());
            else send_item(any_query(), fill_keys[idx] + t_key'(int'($urandom_range(2)) - 1));
        end
        for (int n = FILL_COUNT - 1; n >= 0; n--) begin
            send_item(MODE_ERASE, fill_keys[n]);
            if ($urandom_range(3) == 0) send_item(any_query(), pick_key());
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.mode     = MODE_INSERT;
        in_ch.key      = '0;
        out_ch.ready   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // every query and an erase on the empty set
        for (int m = MODE_MIN; m <= MODE_FLOOR; m++) send_item(t_mode'(m), KEY_HIGHEST);
        send_item(MODE_ERASE, '0);
        // both extremes and zero, then a duplicate
        send_item(MODE_INSERT, KEY_LOWEST);
        send_item(MODE_INSERT, KEY_HIGHEST);
        send_item(MODE_INSERT, '0);
        send_item(MODE_INSERT, '0);
        // exact matches at both ends and queries that run off either end
        send_item(MODE_FLOOR, KEY_LOWEST);
        send_item(MODE_FLOOR, KEY_HIGHEST);
        send_item(MODE_CEIL,  KEY_HIGHEST);
        send_item(MODE_SUCC,  KEY_HIGHEST);
        send_item(MODE_PRED,  KEY_LOWEST);
        send_item(MODE_PRED,  KEY_HIGHEST);
        send_item(MODE_FLOOR, -1);
        send_item(MODE_CEIL,  1);
        send_item(MODE_MIN,   '0);
        send_item(MODE_MAX,   '0);
        // erase present and absent keys, then floor past the end of one entry
        send_item(MODE_ERASE, '0);
        send_item(MODE_ERASE, '0);
        send_item(MODE_ERASE, KEY_HIGHEST);
        send_item(MODE_FLOOR, KEY_HIGHEST);
        wait_drained();

        // random phases under different idling
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            run_churn(50);
            if (ph == 1 || ph == 2) run_fill_drain();
            wait_drained();
        end

        // let any stray result show up before the verdict
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // give up if the handshakes hang
    initial begin
        #200000;
        $display("Verification failed");
        $finish;
    end

endmodule
